@@ sv/dxt1_block_decoder_top_defines.svh @@
// assertion macros for the bound checker file dbd_checker.sv
`ifndef DXT1_BLOCK_DECODER_TOP_DEFINES_SVH
`define DXT1_BLOCK_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define DBD_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define DBD_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

@@ sv/dbd_pkg.sv @@
package dbd_pkg;

    // input beat: one compressed block
    typedef struct packed {
        logic [15:0] color0;
        logic [15:0] color1;
        logic [31:0] index_bits;
    } t_in_beat;

    // output beat: one row of four rgba pixels
    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] pixel0;
        logic [31:0] pixel1;
        logic [31:0] pixel2;
        logic [31:0] pixel3;
        logic        last;
    } t_out_beat;

    // 8-bit channels, index 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_rgb;

    // widened endpoints and the palette mode
    typedef struct packed {
        t_rgb e0;
        t_rgb e1;
        logic four_color;
    } t_endpoints;

    // four packed rgba entries
    typedef logic [3:0][31:0] t_palette;

    localparam logic [1:0] LAST_ROW     = 2'd3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // ch*255/31 and ch*255/63 as multiply by scaled reciprocal, shift by 20
    localparam logic [28:0] WIDEN5_MUL = 29'd8625630;
    localparam logic [28:0] WIDEN6_MUL = 29'd4244475;
    localparam int          WIDEN_SHIFT = 20;

    // x/3 for x up to 765 as (x*683) >> 11
    localparam logic [20:0] DIV3_MUL   = 21'd683;
    localparam int          DIV3_SHIFT = 11;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [28:0] p;
        p = 29'(v) * WIDEN5_MUL;
        return p[WIDEN_SHIFT +: 8];
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [28:0] p;
        p = 29'(v) * WIDEN6_MUL;
        return p[WIDEN_SHIFT +: 8];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * DIV3_MUL;
        return p[DIV3_SHIFT +: 8];
    endfunction

endpackage

@@ sv/dbd_expand.sv @@
module dbd_expand import dbd_pkg::*; (
    input  logic [15:0] i_color0,
    input  logic [15:0] i_color1,
    output t_endpoints  o_endpoints
);

    // rgb565 to rgb888 and palette mode select
    always_comb begin
        o_endpoints.e0[0]      = widen5(i_color0[15:11]);
        o_endpoints.e0[1]      = widen6(i_color0[10:5]);
        o_endpoints.e0[2]      = widen5(i_color0[4:0]);
        o_endpoints.e1[0]      = widen5(i_color1[15:11]);
        o_endpoints.e1[1]      = widen6(i_color1[10:5]);
        o_endpoints.e1[2]      = widen5(i_color1[4:0]);
        o_endpoints.four_color = i_color0 > i_color1;
    end

endmodule

@@ sv/dbd_palette.sv @@
module dbd_palette import dbd_pkg::*; (
    input  t_endpoints i_endpoints,
    output t_palette   o_palette
);

    logic [2:0][9:0] w_near0_sum;
    logic [2:0][9:0] w_near1_sum;
    logic [2:0][8:0] w_mid_sum;
    t_rgb            w_p2;
    t_rgb            w_p3;

    // interpolated entries, per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_near0_sum[ch] = {1'b0, i_endpoints.e0[ch], 1'b0} + {2'b00, i_endpoints.e1[ch]};
            w_near1_sum[ch] = {2'b00, i_endpoints.e0[ch]} + {1'b0, i_endpoints.e1[ch], 1'b0};
            w_mid_sum[ch]   = {1'b0, i_endpoints.e0[ch]} + {1'b0, i_endpoints.e1[ch]};
            if (i_endpoints.four_color) begin
                w_p2[ch] = div3(w_near0_sum[ch]);
                w_p3[ch] = div3(w_near1_sum[ch]);
            end else begin
                w_p2[ch] = w_mid_sum[ch][8:1];
                w_p3[ch] = 8'd0;
            end
        end
    end

    // pack rgba, three-color mode makes entry 3 transparent black
    always_comb begin
        o_palette[0] = {ALPHA_OPAQUE, i_endpoints.e0[2], i_endpoints.e0[1], i_endpoints.e0[0]};
        o_palette[1] = {ALPHA_OPAQUE, i_endpoints.e1[2], i_endpoints.e1[1], i_endpoints.e1[0]};
        o_palette[2] = {ALPHA_OPAQUE, w_p2[2], w_p2[1], w_p2[0]};
        o_palette[3] = i_endpoints.four_color ? {ALPHA_OPAQUE, w_p3[2], w_p3[1], w_p3[0]}
                                              : 32'd0;
    end

endmodule

@@ sv/dbd_row_out.sv @@
module dbd_row_out import dbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_palette  i_palette,
    input  logic [31:0] i_index_bits,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_palette        r_pal;
    logic [3:0][7:0] r_idx;
    logic            r_busy;
    logic [1:0]      r_row;
    t_out_beat       r_out;
    logic            r_out_valid;

    logic       w_out_load;
    logic       w_row_done;
    logic [7:0] w_row_bits;
    t_out_beat  n_out;

    // a row moves into the output register whenever it is empty or drained
    assign w_out_load = r_busy && (!r_out_valid || !i_out_stall);
    assign w_row_done = w_out_load && (r_row == LAST_ROW);
    assign o_free     = !r_busy || w_row_done;

    // palette lookup for the current row
    always_comb begin
        w_row_bits   = r_idx[r_row];
        n_out.row    = r_row;
        n_out.pixel0 = r_pal[w_row_bits[1:0]];
        n_out.pixel1 = r_pal[w_row_bits[3:2]];
        n_out.pixel2 = r_pal[w_row_bits[5:4]];
        n_out.pixel3 = r_pal[w_row_bits[7:6]];
        n_out.last   = (r_row == LAST_ROW);
    end

    // block holding stage and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 2'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_row  <= 2'd0;
        end else begin
            if (w_row_done) begin
                r_busy <= 1'b0;
            end
            if (w_out_load) begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pal <= i_palette;
            r_idx <= i_index_bits;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/dxt1_block_decoder_top.sv @@
// dxt1 block decoder
// input channel: i_in_valid / o_in_stall carry one beat per compressed block,
// two rgb565 endpoints and 32 index bits (byte n is row n).
// output channel: o_out_valid / i_out_stall carry one beat per pixel row, four
// rgba pixels, the row number and a last flag on row 3.
// a beat moves on a rising edge with valid high and stall low.
// a taken block passes the input, endpoint and palette registers before
// row 0 is in the output register; rows 1 to 3 follow while not stalled.
// throughput: one row beat every cycle while the receiver does not stall;
// the output register is the limit, as each block needs four row beats.
// pipeline: input register, endpoint widening register, palette register with
// its row counter, output register; a new block enters while earlier blocks
// are still being widened or emitted.
// reset: all stages empty, no output beat pending, input not stalled.
// receiver stall: the output beat holds, the row counter waits, the stages
// behind fill up and o_in_stall rises once they are all full.
module dxt1_block_decoder_top import dbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_in_beat    r_in;
    logic        r_in_valid;
    t_endpoints  r_ep;
    logic [31:0] r_ep_idx;
    logic        r_ep_valid;

    t_endpoints  w_endpoints;
    t_palette    w_palette;
    logic        w_row_free;
    logic        w_in_acc;
    logic        w_s1_adv;
    logic        w_s2_adv;
    logic        w_s2_free;

    // stage flow control
    assign w_s2_adv   = r_ep_valid && w_row_free;
    assign w_s2_free  = !r_ep_valid || w_row_free;
    assign w_s1_adv   = r_in_valid && w_s2_free;
    assign o_in_stall = r_in_valid && !w_s2_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
    end

    dbd_expand u_expand (
        .i_color0    (r_in.color0),
        .i_color1    (r_in.color1),
        .o_endpoints (w_endpoints)
    );

    // widened endpoint register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_ep_valid <= 1'b1;
        end else if (w_s2_adv) begin
            r_ep_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_ep     <= w_endpoints;
            r_ep_idx <= r_in.index_bits;
        end
    end

    dbd_palette u_palette (
        .i_endpoints (r_ep),
        .o_palette   (w_palette)
    );

    dbd_row_out u_row_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_s2_adv),
        .i_palette    (w_palette),
        .i_index_bits (r_ep_idx),
        .o_free       (w_row_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

@@ sv/dbd_checker.sv @@
`include "dxt1_block_decoder_top_defines.svh"

module dbd_checker import dbd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // a stalled output beat holds
    `DBD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data),
        "output beat changed under stall")

    // last flag marks row 3 only
    `DBD_ASSERT_NOW(a_last_row, o_out_valid,
        o_out_data.last == (o_out_data.row == LAST_ROW),
        "last flag does not match row")

    // rows of a block come back to back in order
    `DBD_ASSERT_NEXT(a_row_seq, o_out_valid && !i_out_stall && !o_out_data.last,
        o_out_valid && (o_out_data.row == $past(o_out_data.row) + 2'd1),
        "row beats not consecutive")

    // a stalled input means a block is emitting, so output fills next cycle
    `DBD_ASSERT_NEXT(a_stall_busy, o_in_stall && !o_out_valid, o_out_valid,
        "input stalled with idle output")

endmodule

bind dxt1_block_decoder_top dbd_checker u_dbd_checker (.*);

@@ dv/dxt1_block_decoder_checker.sv @@
`timescale 1ns / 100ps

module dxt1_block_decoder_checker import dbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_rows_pending
);

    // rows predicted for accepted blocks, oldest first
    t_out_beat expected_rows[$];

    // widen a 5- or 6-bit endpoint channel to 8 bits, truncating
    function automatic int expand_channel(input int code, input int max_code);
        return (code * 255) / max_code;
    endfunction

    function automatic logic [31:0] pack_rgba(input int r, input int g, input int b,
                                              input int alpha);
        return {8'(alpha), 8'(b), 8'(g), 8'(r)};
    endfunction

    // four-entry rgba palette of one block
    function automatic t_palette decode_palette(input logic [15:0] c0,
                                                input logic [15:0] c1);
        int       a[3];
        int       b[3];
        int       mix2[3];
        int       mix3[3];
        logic     four_color;
        t_palette pal;
        four_color = (c0 > c1);
        a[0] = expand_channel(int'(c0[15:11]), 31);
        a[1] = expand_channel(int'(c0[10:5]), 63);
        a[2] = expand_channel(int'(c0[4:0]), 31);
        b[0] = expand_channel(int'(c1[15:11]), 31);
        b[1] = expand_channel(int'(c1[10:5]), 63);
        b[2] = expand_channel(int'(c1[4:0]), 31);
        for (int ch = 0; ch < 3; ch++) begin
            if (four_color) begin
                mix2[ch] = (2 * a[ch] + b[ch]) / 3;
                mix3[ch] = (a[ch] + 2 * b[ch]) / 3;
            end else begin
                mix2[ch] = (a[ch] + b[ch]) / 2;
                mix3[ch] = 0;
            end
        end
        pal[0] = pack_rgba(a[0], a[1], a[2], 255);
        pal[1] = pack_rgba(b[0], b[1], b[2], 255);
        pal[2] = pack_rgba(mix2[0], mix2[1], mix2[2], 255);
        // three-color mode: entry 3 is transparent black
        pal[3] = four_color ? pack_rgba(mix3[0], mix3[1], mix3[2], 255) : '0;
        return pal;
    endfunction

    initial begin
        o_fail_count   = 0;
        o_rows_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_palette   pal;
        logic [7:0] sel;
        t_out_beat  row_beat;
        t_out_beat  want;
        bit         bad;

        // input beat: predict its four rows
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            pal = decode_palette(i_in_data.color0, i_in_data.color1);
            for (int r = 0; r < 4; r++) begin
                sel             = i_in_data.index_bits[8 * r +: 8];
                row_beat.row    = 2'(r);
                row_beat.pixel0 = pal[sel[1:0]];
                row_beat.pixel1 = pal[sel[3:2]];
                row_beat.pixel2 = pal[sel[5:4]];
                row_beat.pixel3 = pal[sel[7:6]];
                row_beat.last   = (row_beat.row == LAST_ROW);
                expected_rows.insert(expected_rows.size(), row_beat);
            end
        end

        // output beat: compare with the oldest prediction
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_rows.size() == 0) begin
                $error("row beat with nothing expected: %h", i_out_data);
                o_fail_count++;
            end else begin
                want = expected_rows.pop_front();
                bad  = 0;
                if (i_out_data.row !== want.row) begin
                    $error("row: expected %0d, got %0d", want.row, i_out_data.row);
                    bad = 1;
                end
                if (i_out_data.pixel0 !== want.pixel0) begin
                    $error("pixel0: expected %h, got %h", want.pixel0, i_out_data.pixel0);
                    bad = 1;
                end
                if (i_out_data.pixel1 !== want.pixel1) begin
                    $error("pixel1: expected %h, got %h", want.pixel1, i_out_data.pixel1);
                    bad = 1;
                end
                if (i_out_data.pixel2 !== want.pixel2) begin
                    $error("pixel2: expected %h, got %h", want.pixel2, i_out_data.pixel2);
                    bad = 1;
                end
                if (i_out_data.pixel3 !== want.pixel3) begin
                    $error("pixel3: expected %h, got %h", want.pixel3, i_out_data.pixel3);
                    bad = 1;
                end
                if (i_out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, i_out_data.last);
                    bad = 1;
                end
                if (bad)
                    o_fail_count++;
            end
        end

        o_rows_pending = expected_rows.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import dbd_pkg::*;

    localparam int RANDOM_BLOCKS  = 256;
    localparam int CALM_BLOCKS    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    int fail_count;
    int rows_pending;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit idle_enabled = 1'b1;

    always #4 i_clk = ~i_clk;

    dxt1_block_decoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    dxt1_block_decoder_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_data     (o_out_data),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    // receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left  = $urandom_range(1, 16) - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // one block beat; called at a falling edge, returns at a falling edge with valid high
    task automatic send_block(input t_in_beat blk);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap        = $urandom_range(1, 16);
            i_in_valid = 1'b0;
            i_in_data  = {$urandom, $urandom};
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_in_beat blk;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed blocks: extremes, both palette modes, equal endpoints
        send_block({16'hFFFF, 16'h0000, 32'hE4E4E4E4});
        send_block({16'h0000, 16'hFFFF, 32'hE4E4E4E4});
        send_block({16'h0000, 16'h0000, 32'hFFFFFFFF});
        send_block({16'hFFFF, 16'hFFFF, 32'hAAAAAAAA});
        send_block({16'h8410, 16'h8410, 32'h1B1B1B1B});
        send_block({16'hF800, 16'h001F, 32'hE4E4E4E4});
        send_block({16'h001F, 16'hF800, 32'hE4E4E4E4});
        send_block({16'h07E0, 16'h0000, 32'h55555555});
        send_block({16'h0001, 16'h0000, 32'h00000000});
        send_block({16'h0000, 16'h0001, 32'hFFFFFFFF});
        send_block({16'h7BEF, 16'h8410, 32'hE41B4EB1});
        send_block({16'h8410, 16'h7BEF, 32'hB14E1BE4});
        send_block({16'hFFFE, 16'hFFFF, 32'h39C6E4E4});
        send_block({16'hA5A5, 16'h5A5A, 32'h00FF00FF});

        // hold off until the directed rows are all out
        i_in_valid = 1'b0;
        while (rows_pending != 0) @(negedge i_clk);

        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            if (n == RANDOM_BLOCKS - CALM_BLOCKS)
                idle_enabled = 1'b0;
            if (n == RANDOM_BLOCKS / 2) begin
                i_in_valid = 1'b0;
                while (rows_pending != 0) @(negedge i_clk);
            end
            blk.color0     = 16'($urandom);
            blk.color1     = 16'($urandom);
            blk.index_bits = $urandom;
            // equal endpoints now and then
            if ($urandom_range(0, 7) == 0)
                blk.color1 = blk.color0;
            send_block(blk);
        end
        i_in_valid = 1'b0;

        while (rows_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dbd_pkg.sv
sv/dbd_expand.sv
sv/dbd_palette.sv
sv/dbd_row_out.sv
sv/dxt1_block_decoder_top.sv
sv/dbd_checker.sv
dv/dxt1_block_decoder_checker.sv
dv/testbench.sv
